// ===== hdl/kvt_pkg.sv =====
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int TABLE_DEPTH_DEF = 8;
	localparam int KEY_W           = 32;
	localparam int VALUE_W         = 32;
	localparam int OPCODE_W        = 2;
	localparam int STATUS_W        = 2;
	localparam int CAP_W           = 4;
	localparam int COUNT_OUT_W     = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// controller -> datapath strobes
	typedef struct packed {
		logic    load_item;
		logic    rd_en;
		logic    wr_en;
		logic    wr_from_rd;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
		logic    res_load;
		status_t res_status;
		logic    res_found;
	} dp_cmd_t;

	// datapath -> controller flags
	typedef struct packed {
		op_t  op;
		logic key_match;
		logic full;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hdl/kvt_req_if.sv =====
`timescale 1ns / 1ps

interface kvt_req_if;
	logic                                valid;
	logic                                ready;
	logic [kvt_pkg::OPCODE_W-1:0]        opcode;
	logic signed [kvt_pkg::KEY_W-1:0]    key;
	logic signed [kvt_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output opcode, output key, output value, input ready);
	modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

// ===== hdl/kvt_rsp_if.sv =====
`timescale 1ns / 1ps

interface kvt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [kvt_pkg::STATUS_W-1:0]         status;
	logic signed [kvt_pkg::VALUE_W-1:0]   found_value;
	logic [kvt_pkg::COUNT_OUT_W-1:0]      entry_count;
	logic                                 is_empty;

	modport source (output valid, output status, output found_value, output entry_count,
		output is_empty, input ready);
	modport sink   (input valid, input status, input found_value, input entry_count,
		input is_empty, output ready);
endinterface

// ===== hdl/kvt_cfg_if.sv =====
`timescale 1ns / 1ps

interface kvt_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [kvt_pkg::CAP_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/key_value_table_linear_search_top.sv =====
`timescale 1ns / 1ps
// One operation at a time: the next word is taken only once the previous one has loaded
//   its result, later while an earlier result still waits for ready. Find, remove and insert
//   scan the stored entries in order; clear and an insert into a full table skip the scan;
//   remove then moves each later entry down by one.
// Reset (arst_n low, async): count cleared, capacity back to 5, no result pending;
//   table memory contents are not cleared, they are only read below the count.

module key_value_table_linear_search_top #(
	parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp,
	kvt_cfg_if.sink   cfg
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	kvt_pkg::dp_cmd_t  cmd;
	kvt_pkg::dp_stat_t stat;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [CW-1:0]     count;

	// Capacity register is always writable; it is to be written only while no
	// operation is in flight.
	assign cfg.ready = 1'b1;

	// Controller: sequences scan, shift-down and commit per operation word.
	kvt_controller #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.count    (count),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	// Datapath: table memory, operand registers, count, capacity and result register.
	// The result register lets a new word enter while the previous result waits.
	kvt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.wr_addr         (wr_addr),
		.stat            (stat),
		.count           (count),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.data),
		.in_opcode       (req.opcode),
		.in_key          (req.key),
		.in_value        (req.value),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_found_value (rsp.found_value),
		.out_entry_count (rsp.entry_count),
		.out_is_empty    (rsp.is_empty)
	);

endmodule

// ===== hdl/kvt_datapath.sv =====
`timescale 1ns / 1ps

module kvt_datapath #(
	parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEF,
	localparam int CW = $clog2(TABLE_DEPTH + 1),
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kvt_pkg::dp_cmd_t                   cmd,
	input  logic [AW-1:0]                      rd_addr,
	input  logic [AW-1:0]                      wr_addr,
	output kvt_pkg::dp_stat_t                  stat,
	output logic [CW-1:0]                      count,
	input  logic                               cfg_we,
	input  logic [kvt_pkg::CAP_W-1:0]          cfg_data,
	input  logic [kvt_pkg::OPCODE_W-1:0]       in_opcode,
	input  logic signed [kvt_pkg::KEY_W-1:0]   in_key,
	input  logic signed [kvt_pkg::VALUE_W-1:0] in_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kvt_pkg::STATUS_W-1:0]       out_status,
	output logic signed [kvt_pkg::VALUE_W-1:0] out_found_value,
	output logic [kvt_pkg::COUNT_OUT_W-1:0]    out_entry_count,
	output logic                               out_is_empty
);

	localparam int CMPW = (CW > kvt_pkg::CAP_W) ? CW : kvt_pkg::CAP_W;

	logic signed [kvt_pkg::KEY_W-1:0]   key_mem [TABLE_DEPTH];
	logic signed [kvt_pkg::VALUE_W-1:0] val_mem [TABLE_DEPTH];

	kvt_pkg::op_t                       op_q;
	logic signed [kvt_pkg::KEY_W-1:0]   key_q;
	logic signed [kvt_pkg::VALUE_W-1:0] val_q;
	logic signed [kvt_pkg::KEY_W-1:0]   rd_key_q;
	logic signed [kvt_pkg::VALUE_W-1:0] rd_val_q;
	logic [CW-1:0]                      count_q;
	logic [kvt_pkg::CAP_W-1:0]          cap_q;
	logic                               out_valid_q;
	logic [kvt_pkg::STATUS_W-1:0]       res_status_q;
	logic signed [kvt_pkg::VALUE_W-1:0] res_found_q;
	logic [kvt_pkg::COUNT_OUT_W-1:0]    res_count_q;
	logic                               res_empty_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cap_q       <= kvt_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operand, read-back and result words
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= kvt_pkg::op_t'(in_opcode);
			key_q <= in_key;
			val_q <= in_value;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_found_q  <= cmd.res_found ? rd_val_q : '0;
			res_count_q  <= kvt_pkg::COUNT_OUT_W'(count_q);
			res_empty_q  <= (count_q == '0);
		end
	end

	// table memory, one write port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_mem[wr_addr] <= cmd.wr_from_rd ? rd_key_q : key_q;
			val_mem[wr_addr] <= cmd.wr_from_rd ? rd_val_q : val_q;
		end
	end

	always_comb begin
		stat.op        = op_q;
		stat.key_match = (rd_key_q == key_q);
		stat.full      = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q >= CW'(TABLE_DEPTH));
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign count           = count_q;
	assign out_valid       = out_valid_q;
	assign out_status      = res_status_q;
	assign out_found_value = res_found_q;
	assign out_entry_count = res_count_q;
	assign out_is_empty    = res_empty_q;

endmodule

// ===== hdl/kvt_controller.sv =====
`timescale 1ns / 1ps

module kvt_controller #(
	parameter int TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEF,
	localparam int CW = $clog2(TABLE_DEPTH + 1),
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kvt_pkg::dp_stat_t stat,
	input  logic [CW-1:0]     count,
	output kvt_pkg::dp_cmd_t  cmd,
	output logic [AW-1:0]     rd_addr,
	output logic [AW-1:0]     wr_addr
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_COMMIT,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     idx_q;     // next entry to read during scan
	logic [CW-1:0]     pos_q;     // entry under compare, then shift cursor
	logic              pend_q;    // a read is waiting for compare
	kvt_pkg::status_t  status_q;
	logic              found_q;

	logic          hit;
	logic          more;
	logic [CW-1:0] pos_nxt;
	logic          ins_commit;

	always_comb begin
		hit        = pend_q && stat.key_match;
		more       = (idx_q < count);
		pos_nxt    = pos_q + 1'b1;
		ins_commit = (state_q == S_COMMIT) && (stat.op == kvt_pkg::OP_INSERT)
			&& (status_q == kvt_pkg::ST_OK);

		in_ready = (state_q == S_IDLE);

		cmd.load_item  = (state_q == S_IDLE) && in_valid;
		cmd.rd_en      = ((state_q == S_SCAN) && !hit && more)
			|| ((state_q == S_SHIFT_RD) && (pos_nxt < count));
		cmd.wr_en      = ins_commit || (state_q == S_SHIFT_WR);
		cmd.wr_from_rd = (state_q == S_SHIFT_WR);
		cmd.cnt_inc    = ins_commit;
		cmd.cnt_dec    = (state_q == S_COMMIT) && (stat.op == kvt_pkg::OP_REMOVE)
			&& (status_q == kvt_pkg::ST_OK);
		cmd.cnt_clr    = (state_q == S_COMMIT) && (stat.op == kvt_pkg::OP_CLEAR);
		cmd.res_load   = (state_q == S_FINISH) && stat.out_free;
		cmd.res_status = status_q;
		cmd.res_found  = found_q;

		rd_addr = (state_q == S_SHIFT_RD) ? pos_nxt[AW-1:0] : idx_q[AW-1:0];
		wr_addr = (state_q == S_SHIFT_WR) ? pos_q[AW-1:0] : count[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			pos_q    <= '0;
			pend_q   <= 1'b0;
			status_q <= kvt_pkg::ST_OK;
			found_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					found_q  <= 1'b0;
					status_q <= kvt_pkg::ST_OK;
					idx_q    <= '0;
					pend_q   <= 1'b0;
					case (stat.op)
						kvt_pkg::OP_CLEAR: begin
							state_q <= S_COMMIT;
						end
						kvt_pkg::OP_INSERT: begin
							if (stat.full) begin
								status_q <= kvt_pkg::ST_FULL;
								state_q  <= S_COMMIT;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: begin
							state_q <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					if (hit) begin
						case (stat.op)
							kvt_pkg::OP_INSERT: begin
								status_q <= kvt_pkg::ST_DUP;
								state_q  <= S_COMMIT;
							end
							kvt_pkg::OP_FIND: begin
								found_q <= 1'b1;
								state_q <= S_COMMIT;
							end
							kvt_pkg::OP_REMOVE: begin
								state_q <= S_SHIFT_RD;
							end
							default: begin
								state_q <= S_COMMIT;
							end
						endcase
					end else if (more) begin
						pend_q <= 1'b1;
						pos_q  <= idx_q;
						idx_q  <= idx_q + 1'b1;
					end else begin
						if (stat.op != kvt_pkg::OP_INSERT) begin
							status_q <= kvt_pkg::ST_MISSING;
						end
						state_q <= S_COMMIT;
					end
				end
				S_SHIFT_RD: begin
					if (pos_nxt < count) begin
						state_q <= S_SHIFT_WR;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_SHIFT_WR: begin
					pos_q   <= pos_nxt;
					state_q <= S_SHIFT_RD;
				end
				S_COMMIT: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/kvt_checker.sv =====
`timescale 1ns / 1ps

module kvt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic [kvt_pkg::STATUS_W-1:0]       rsp_status,
	input logic signed [kvt_pkg::VALUE_W-1:0] rsp_found_value,
	input logic [kvt_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
	input logic                               rsp_is_empty
);

	// one operation in flight: no second word right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// empty flag agrees with the count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_empty |-> rsp_entry_count == '0)
		else $error("empty flag with nonzero count");

	// value only reported on success
	a_value_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found_value != '0 |-> rsp_status == kvt_pkg::ST_OK)
		else $error("value reported on failed operation");

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found_value) && $stable(rsp_entry_count))
		else $error("stalled result changed");

endmodule

bind key_value_table_linear_search_top kvt_checker u_kvt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_value (rsp.found_value),
	.rsp_entry_count (rsp.entry_count),
	.rsp_is_empty    (rsp.is_empty)
);
